>>> design/virtual_register_allocator_defines.svh
`ifndef VIRTUAL_REGISTER_ALLOCATOR_DEFINES_SVH
`define VIRTUAL_REGISTER_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define VRA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VRA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/vra_pkg.sv
package vra_pkg;

    localparam int VIRTUAL_REGS = 256;
    localparam int PHYS_REGS    = 8;
    localparam int VIDX_W       = $clog2(VIRTUAL_REGS);
    localparam int PHYS_W       = $clog2(PHYS_REGS);

    typedef logic [VIDX_W-1:0]    vidx_t;
    typedef logic [PHYS_W-1:0]    phys_t;
    typedef logic [PHYS_REGS-1:0] busy_t;
    typedef logic [VIRTUAL_REGS-1:0] vmask_t;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_ALLOC_L   = 3'd1,
        ACT_ALLOC_LR  = 3'd2,
        ACT_ALLOC_ARG = 3'd3,
        ACT_KILL      = 3'd4,
        ACT_NEW_FN    = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_BAD_KILL  = 2'd2,
        ST_STALE     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LHS,
        S_RHS,
        S_FIN,
        S_WR2
    } state_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] lhs_vreg;
        logic [7:0] rhs_vreg;
    } req_item_t;

    typedef struct packed {
        logic [2:0] lhs_phys;
        logic [2:0] rhs_phys;
        logic       lhs_written;
        logic       rhs_written;
        logic       became_nop;
        status_t    status;
    } rsp_item_t;

    typedef struct packed {
        logic accept;
        logic eval_lhs;
        logic eval_rhs;
        logic commit;
        logic write_rhs;
    } cmd_t;

    typedef struct packed {
        logic need_rhs;
        logic out_free;
        logic rhs_pending;
    } dp_status_t;

    typedef struct packed {
        status_t status;
        phys_t   phys;
        logic    is_new;
        busy_t   busy;
    } alloc_res_t;

endpackage

>>> design/vra_if.sv
interface vra_req_if;
    logic                 valid;
    logic                 ready;
    vra_pkg::req_item_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface vra_rsp_if;
    logic                 valid;
    logic                 ready;
    vra_pkg::rsp_item_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/vra_ram.sv
module vra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> design/vra_ctrl.sv
module vra_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  vra_pkg::dp_status_t stat,
    output vra_pkg::cmd_t       cmd
);

    vra_pkg::state_t state_reg;
    vra_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vra_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vra_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = vra_pkg::S_LHS;
                end
            end
            vra_pkg::S_LHS:
            begin
                state_next = stat.need_rhs ? vra_pkg::S_RHS : vra_pkg::S_FIN;
            end
            vra_pkg::S_RHS:
            begin
                state_next = vra_pkg::S_FIN;
            end
            vra_pkg::S_FIN:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.rhs_pending ? vra_pkg::S_WR2 : vra_pkg::S_IDLE;
                end
            end
            vra_pkg::S_WR2:
            begin
                state_next = vra_pkg::S_IDLE;
            end
            default:
            begin
                state_next = vra_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready     = 1'b0;
        cmd           = '0;
        case (state_reg)
            vra_pkg::S_IDLE:
            begin
                req_ready  = 1'b1;
                cmd.accept = req_valid;
            end
            vra_pkg::S_LHS:
            begin
                cmd.eval_lhs = 1'b1;
            end
            vra_pkg::S_RHS:
            begin
                cmd.eval_rhs = 1'b1;
            end
            vra_pkg::S_FIN:
            begin
                cmd.commit = stat.out_free;
            end
            vra_pkg::S_WR2:
            begin
                cmd.write_rhs = 1'b1;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> design/vra_dp.sv
module vra_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  vra_pkg::cmd_t       cmd,
    output vra_pkg::dp_status_t stat,
    input  vra_pkg::req_item_t  req_data,
    input  logic                rsp_ready,
    output logic                rsp_valid,
    output vra_pkg::rsp_item_t  rsp_data
);

    // lookup or lowest-free allocation in one pool
    function automatic vra_pkg::alloc_res_t pool_alloc(
        input logic           hit,
        input vra_pkg::phys_t map,
        input vra_pkg::busy_t busy
    );
        vra_pkg::alloc_res_t r;
        logic                found;
        r.status = vra_pkg::ST_OK;
        r.phys   = '0;
        r.is_new = 1'b0;
        r.busy   = busy;
        found    = 1'b0;
        if (hit)
        begin
            if (busy[map])
            begin
                r.phys = map;
            end
            else
            begin
                r.status = vra_pkg::ST_STALE;
            end
        end
        else
        begin
            for (int i = 0; i < vra_pkg::PHYS_REGS; i++)
            begin
                if (!found && !busy[i])
                begin
                    found     = 1'b1;
                    r.phys    = vra_pkg::phys_t'(i);
                    r.is_new  = 1'b1;
                    r.busy[i] = 1'b1;
                end
            end
            if (!found)
            begin
                r.status = vra_pkg::ST_EXHAUSTED;
            end
        end
        return r;
    endfunction

    // control state
    vra_pkg::busy_t     saved_busy_reg,  saved_busy_next;
    vra_pkg::busy_t     arg_busy_reg,    arg_busy_next;
    vra_pkg::vmask_t    saved_valid_reg, saved_valid_next;
    vra_pkg::vmask_t    arg_valid_reg,   arg_valid_next;
    logic               out_valid_reg,   out_valid_next;

    // payload
    logic [2:0]         act_reg,       act_next;
    vra_pkg::vidx_t     lv_reg,        lv_next;
    vra_pkg::vidx_t     rv_reg,        rv_next;
    vra_pkg::busy_t     work_busy_reg, work_busy_next;
    vra_pkg::phys_t     lp_reg,        lp_next;
    vra_pkg::phys_t     rp_reg,        rp_next;
    logic               lhs_new_reg,   lhs_new_next;
    logic               rhs_new_reg,   rhs_new_next;
    logic               nop_reg,       nop_next;
    vra_pkg::status_t   status_reg,    status_next;
    vra_pkg::rsp_item_t out_reg,       out_next;

    vra_pkg::vidx_t      rd_addr;
    vra_pkg::phys_t      saved_rd;
    vra_pkg::phys_t      arg_rd;
    logic                saved_wr_en;
    vra_pkg::vidx_t      saved_wr_addr;
    vra_pkg::phys_t      saved_wr_data;
    logic                arg_wr_en;

    logic                pool_arg;
    logic                lhs_hit;
    vra_pkg::phys_t      lhs_map;
    vra_pkg::busy_t      lhs_busy;
    vra_pkg::alloc_res_t lhs_res;
    vra_pkg::alloc_res_t rhs_res;
    logic                kill_ok;
    logic                ok;
    logic                lw;
    logic                rw;

    vra_ram #(.WIDTH(vra_pkg::PHYS_W), .DEPTH(vra_pkg::VIRTUAL_REGS)) u_saved_map (
        .clk     (clk),
        .wr_en   (saved_wr_en),
        .wr_addr (saved_wr_addr),
        .wr_data (saved_wr_data),
        .rd_addr (rd_addr),
        .rd_data (saved_rd)
    );

    vra_ram #(.WIDTH(vra_pkg::PHYS_W), .DEPTH(vra_pkg::VIRTUAL_REGS)) u_arg_map (
        .clk     (clk),
        .wr_en   (arg_wr_en),
        .wr_addr (lv_reg),
        .wr_data (lp_reg),
        .rd_addr (rd_addr),
        .rd_data (arg_rd)
    );

    // lhs read issued on accept, rhs read in the cycle after
    assign rd_addr = cmd.accept ? req_data.lhs_vreg[vra_pkg::VIDX_W-1:0] : rv_reg;

    assign pool_arg = (act_reg == vra_pkg::ACT_ALLOC_ARG);
    assign lhs_hit  = pool_arg ? arg_valid_reg[lv_reg] : saved_valid_reg[lv_reg];
    assign lhs_map  = pool_arg ? arg_rd : saved_rd;
    assign lhs_busy = pool_arg ? arg_busy_reg : saved_busy_reg;
    assign lhs_res  = pool_alloc(lhs_hit, lhs_map, lhs_busy);
    assign rhs_res  = pool_alloc(saved_valid_reg[rv_reg], saved_rd, work_busy_reg);
    assign kill_ok  = saved_valid_reg[lv_reg] && saved_busy_reg[saved_rd];

    assign ok = (status_reg == vra_pkg::ST_OK);
    assign lw = ok && (act_reg inside {vra_pkg::ACT_ALLOC_L, vra_pkg::ACT_ALLOC_LR,
                                       vra_pkg::ACT_ALLOC_ARG});
    assign rw = ok && (act_reg == vra_pkg::ACT_ALLOC_LR);

    assign saved_wr_en   = (cmd.commit && ok && lhs_new_reg && !pool_arg) || cmd.write_rhs;
    assign saved_wr_addr = cmd.write_rhs ? rv_reg : lv_reg;
    assign saved_wr_data = cmd.write_rhs ? rp_reg : lp_reg;
    assign arg_wr_en     = cmd.commit && ok && lhs_new_reg && pool_arg;

    assign stat.need_rhs    = (act_reg == vra_pkg::ACT_ALLOC_LR) &&
                              (lhs_res.status == vra_pkg::ST_OK);
    assign stat.out_free    = !out_valid_reg || rsp_ready;
    assign stat.rhs_pending = ok && rhs_new_reg;

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

    always_comb
    begin
        saved_busy_next  = saved_busy_reg;
        arg_busy_next    = arg_busy_reg;
        saved_valid_next = saved_valid_reg;
        arg_valid_next   = arg_valid_reg;
        out_valid_next   = out_valid_reg;
        act_next         = act_reg;
        lv_next          = lv_reg;
        rv_next          = rv_reg;
        work_busy_next   = work_busy_reg;
        lp_next          = lp_reg;
        rp_next          = rp_reg;
        lhs_new_next     = lhs_new_reg;
        rhs_new_next     = rhs_new_reg;
        nop_next         = nop_reg;
        status_next      = status_reg;
        out_next         = out_reg;

        if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.accept)
        begin
            act_next = req_data.action;
            lv_next  = req_data.lhs_vreg[vra_pkg::VIDX_W-1:0];
            rv_next  = req_data.rhs_vreg[vra_pkg::VIDX_W-1:0];
        end

        if (cmd.eval_lhs)
        begin
            status_next    = vra_pkg::ST_OK;
            lp_next        = '0;
            rp_next        = '0;
            lhs_new_next   = 1'b0;
            rhs_new_next   = 1'b0;
            nop_next       = 1'b0;
            work_busy_next = lhs_busy;
            case (act_reg)
                vra_pkg::ACT_ALLOC_L, vra_pkg::ACT_ALLOC_LR, vra_pkg::ACT_ALLOC_ARG:
                begin
                    status_next    = lhs_res.status;
                    lp_next        = lhs_res.phys;
                    lhs_new_next   = lhs_res.is_new;
                    work_busy_next = lhs_res.busy;
                end
                vra_pkg::ACT_KILL:
                begin
                    if (kill_ok)
                    begin
                        work_busy_next = saved_busy_reg & ~(vra_pkg::busy_t'(1) << saved_rd);
                        nop_next       = 1'b1;
                    end
                    else
                    begin
                        status_next = vra_pkg::ST_BAD_KILL;
                    end
                end
                default:
                begin
                    status_next = vra_pkg::ST_OK;
                end
            endcase
        end

        if (cmd.eval_rhs)
        begin
            if (rv_reg == lv_reg)
            begin
                rp_next = lp_reg;
            end
            else
            begin
                status_next    = rhs_res.status;
                rp_next        = rhs_res.phys;
                rhs_new_next   = rhs_res.is_new;
                work_busy_next = rhs_res.busy;
            end
        end

        if (cmd.commit)
        begin
            out_valid_next       = 1'b1;
            out_next.lhs_phys    = lw ? lp_reg : '0;
            out_next.rhs_phys    = rw ? rp_reg : '0;
            out_next.lhs_written = lw;
            out_next.rhs_written = rw;
            out_next.became_nop  = ok && nop_reg;
            out_next.status      = status_reg;
            if (ok)
            begin
                case (act_reg)
                    vra_pkg::ACT_ALLOC_ARG:
                    begin
                        arg_busy_next = work_busy_reg;
                        if (lhs_new_reg)
                        begin
                            arg_valid_next[lv_reg] = 1'b1;
                        end
                    end
                    vra_pkg::ACT_ALLOC_L, vra_pkg::ACT_ALLOC_LR:
                    begin
                        saved_busy_next = work_busy_reg;
                        if (lhs_new_reg)
                        begin
                            saved_valid_next[lv_reg] = 1'b1;
                        end
                        if (rhs_new_reg)
                        begin
                            saved_valid_next[rv_reg] = 1'b1;
                        end
                    end
                    vra_pkg::ACT_KILL:
                    begin
                        saved_busy_next = work_busy_reg;
                    end
                    vra_pkg::ACT_NEW_FN:
                    begin
                        saved_valid_next = '0;
                        arg_valid_next   = '0;
                    end
                    default:
                    begin
                        saved_busy_next = saved_busy_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            saved_busy_reg  <= '0;
            arg_busy_reg    <= '0;
            saved_valid_reg <= '0;
            arg_valid_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            saved_busy_reg  <= saved_busy_next;
            arg_busy_reg    <= arg_busy_next;
            saved_valid_reg <= saved_valid_next;
            arg_valid_reg   <= arg_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        lv_reg        <= lv_next;
        rv_reg        <= rv_next;
        work_busy_reg <= work_busy_next;
        lp_reg        <= lp_next;
        rp_reg        <= rp_next;
        lhs_new_reg   <= lhs_new_next;
        rhs_new_reg   <= rhs_new_next;
        nop_reg       <= nop_next;
        status_reg    <= status_next;
        out_reg       <= out_next;
    end

endmodule

>>> design/virtual_register_allocator.sv
// Maps virtual registers 0..255 onto a saved pool and an argument pool of eight
// physical registers each, handing out the lowest free register or the existing
// mapping, with kill and new-function actions; errors leave all state untouched
// and are reported in status. One beat is in flight at a time: a single-target
// action steps from accept with map table read, through lookup and allocate, to
// commit into the output register before the next accept; an lhs-and-rhs
// allocation adds an rhs lookup step (skipped when the lhs lookup already fails)
// and, whenever rhs gets a new mapping, a step after the commit that writes it,
// since the saved map table has one write port. The output register lets the
// next beat be accepted while a result waits; the commit step stalls only while
// a previous result is still unclaimed. No clearing pass is needed after reset.
`include "virtual_register_allocator_defines.svh"

module virtual_register_allocator (
    input  logic      clk,
    input  logic      rst_n,
    vra_req_if.sink   req,
    vra_rsp_if.source rsp
);

    vra_pkg::cmd_t       cmd;
    vra_pkg::dp_status_t stat;

    vra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    vra_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .req_data  (req.data),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .rsp_data  (rsp.data)
    );

    `VRA_ASSERT_NEXT(a_accept_then_lookup, cmd.accept, cmd.eval_lhs,
                     "accept not followed by lookup")
    `VRA_ASSERT_NEXT(a_commit_fills_out, cmd.commit, rsp.valid,
                     "commit did not fill output")
    `VRA_ASSERT_NOW(a_error_writes_nothing,
                    rsp.valid && rsp.data.status != vra_pkg::ST_OK,
                    !rsp.data.lhs_written && !rsp.data.rhs_written && !rsp.data.became_nop,
                    "error beat carries a result")
    `VRA_ASSERT_NOW(a_rhs_needs_lhs, rsp.valid && rsp.data.rhs_written,
                    rsp.data.lhs_written, "rhs written without lhs")

endmodule

>>> tb/virtual_register_allocator_checker.sv
module virtual_register_allocator_checker
    import vra_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    vra_req_if   req,
    vra_rsp_if   rsp,
    output int   errors,
    output int   pending
);

    typedef struct packed {
        busy_t                                busy;
        vmask_t                               mapped;
        logic [VIRTUAL_REGS-1:0][PHYS_W-1:0] target;
    } pool_t;

    pool_t     saved_pool;
    pool_t     arg_pool;
    rsp_item_t awaited[$];

    // existing mapping first, otherwise the lowest free register
    function automatic status_t claim(inout pool_t pool, input vidx_t v, output phys_t p);
        int i;
        p = '0;
        if (pool.mapped[v])
        begin
            p = pool.target[v];
            return pool.busy[p] ? ST_OK : ST_STALE;
        end
        for (i = 0; i < PHYS_REGS; i++)
        begin
            if (!pool.busy[i])
            begin
                pool.busy[i]     = 1'b1;
                pool.target[v]   = phys_t'(i);
                pool.mapped[v]   = 1'b1;
                p                = phys_t'(i);
                return ST_OK;
            end
        end
        return ST_EXHAUSTED;
    endfunction

    // works on copies of both pools, committed only when nothing failed
    task automatic resolve(input req_item_t ins, output rsp_item_t res);
        pool_t   sp;
        pool_t   ap;
        phys_t   lp;
        phys_t   rp;
        logic    lw;
        logic    rw;
        logic    nop;
        status_t st;
        vidx_t   lv;
        vidx_t   rv;
        sp  = saved_pool;
        ap  = arg_pool;
        lp  = '0;
        rp  = '0;
        lw  = 1'b0;
        rw  = 1'b0;
        nop = 1'b0;
        st  = ST_OK;
        lv  = ins.lhs_vreg;
        rv  = ins.rhs_vreg;
        case (ins.action)
            ACT_ALLOC_L:
            begin
                st = claim(sp, lv, lp);
                lw = (st == ST_OK);
            end
            ACT_ALLOC_LR:
            begin
                st = claim(sp, lv, lp);
                if (st == ST_OK)
                    st = claim(sp, rv, rp);
                lw = (st == ST_OK);
                rw = lw;
            end
            ACT_ALLOC_ARG:
            begin
                st = claim(ap, lv, lp);
                lw = (st == ST_OK);
            end
            ACT_KILL:
            begin
                if (sp.mapped[lv] && sp.busy[sp.target[lv]])
                begin
                    sp.busy[sp.target[lv]] = 1'b0;
                    nop = 1'b1;
                end
                else
                    st = ST_BAD_KILL;
            end
            ACT_NEW_FN:
            begin
                sp.mapped = '0;
                ap.mapped = '0;
            end
            default:
            begin
            end
        endcase
        if (st == ST_OK)
        begin
            saved_pool = sp;
            arg_pool   = ap;
        end
        res.lhs_phys    = lw ? lp : '0;
        res.rhs_phys    = rw ? rp : '0;
        res.lhs_written = lw;
        res.rhs_written = rw;
        res.became_nop  = nop;
        res.status      = st;
    endtask

    function automatic int differs(string field, logic [2:0] want, logic [2:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        rsp_item_t want;
        rsp_item_t got;
        if (!rst_n)
        begin
            saved_pool = '0;
            arg_pool   = '0;
            awaited.delete();
            errors     = 0;
            pending    = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got = rsp.data;
                if (awaited.size() == 0)
                begin
                    $display("%0t: result beat with nothing outstanding, expected none actual %p",
                             $time, got);
                    errors++;
                end
                else
                begin
                    want = awaited.pop_front();
                    errors += differs("lhs_phys", want.lhs_phys, got.lhs_phys);
                    errors += differs("rhs_phys", want.rhs_phys, got.rhs_phys);
                    errors += differs("lhs_written", want.lhs_written, got.lhs_written);
                    errors += differs("rhs_written", want.rhs_written, got.rhs_written);
                    errors += differs("became_nop", want.became_nop, got.became_nop);
                    errors += differs("status", want.status, got.status);
                end
            end
            if (req.valid && req.ready)
            begin
                resolve(req.data, want);
                awaited.push_back(want);
            end
            pending = awaited.size();
        end
    end

endmodule

>>> tb/virtual_register_allocator_test.sv
module virtual_register_allocator_test;
    import vra_pkg::*;

    localparam logic [2:0] ACT_UNUSED_A = 3'd6;
    localparam logic [2:0] ACT_UNUSED_B = 3'd7;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         CYCLE_LIMIT  = 400000;

    logic       clk;
    logic       rst_n;
    int         errors;
    int         pending;
    int         cycles = 0;
    int         tx_idle_pct = 0;
    int         rx_stall_pct = 0;
    int         hold_asked = 0;
    int         hold_served;
    logic [7:0] live_vregs[$];

    vra_req_if req_ch();
    vra_rsp_if rsp_ch();

    virtual_register_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    virtual_register_allocator_checker allocation_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[virtual_register_allocator] ERROR");
            $finish;
        end
    end

    // result side, with one long hold-off on request
    initial
    begin
        rsp_ch.ready = 1'b0;
        hold_served  = 0;
        forever
        begin
            @(negedge clk);
            if (hold_served != hold_asked)
            begin
                hold_served = hold_asked;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    function automatic logic [7:0] draw_vreg();
        if ($urandom_range(3) == 0)
            return 8'($urandom_range(255));
        return 8'($urandom_range(15));
    endfunction

    function automatic void note_live(logic [7:0] v);
        foreach (live_vregs[i])
            if (live_vregs[i] == v)
                return;
        live_vregs.push_back(v);
    endfunction

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_beat(input logic [2:0] act, input logic [7:0] lv, input logic [7:0] rv);
        req_item_t beat;
        beat.action   = act;
        beat.lhs_vreg = lv;
        beat.rhs_vreg = rv;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= beat;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    // a new function never leaves busy saved registers without a mapping behind
    task automatic issue(input logic [2:0] act, input logic [7:0] lv, input logic [7:0] rv);
        int i;
        if (act == ACT_NEW_FN)
            while (live_vregs.size() > 0)
                send_beat(ACT_KILL, live_vregs.pop_front(), 8'($urandom_range(255)));
        send_beat(act, lv, rv);
        case (act)
            ACT_ALLOC_L:
                note_live(lv);
            ACT_ALLOC_LR:
            begin
                note_live(lv);
                note_live(rv);
            end
            ACT_KILL:
                for (i = live_vregs.size() - 1; i >= 0; i--)
                    if (live_vregs[i] == lv)
                        live_vregs.delete(i);
            default:
            begin
            end
        endcase
    endtask

    task automatic issue_random();
        int         pick;
        logic [2:0] act;
        logic [7:0] lv;
        logic [7:0] rv;
        pick = $urandom_range(99);
        lv   = draw_vreg();
        rv   = draw_vreg();
        if (pick < 26)
            act = ACT_ALLOC_L;
        else if (pick < 46)
            act = ACT_ALLOC_LR;
        else if (pick < 54)
            act = ACT_ALLOC_ARG;
        else if (pick < 82)
        begin
            act = ACT_KILL;
            if (live_vregs.size() > 0 && $urandom_range(9) < 8)
                lv = live_vregs[$urandom_range(live_vregs.size() - 1)];
        end
        else if (pick < 88)
            act = ACT_NONE;
        else if (pick < 92)
            act = $urandom_range(1) ? ACT_UNUSED_A : ACT_UNUSED_B;
        else if (pick < 98)
        begin
            act = 3'($urandom_range(7));
            lv  = 8'($urandom());
            rv  = 8'($urandom());
        end
        else
            act = ACT_NEW_FN;
        issue(act, lv, rv);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    task automatic run_phase(input int tx, input int rx, input int count, input bit with_hold);
        int n;
        drain();
        tx_idle_pct = tx;
        rx_stall_pct <= rx;
        if (with_hold)
            hold_asked <= hold_asked + 1;
        for (n = 0; n < count; n++)
            issue_random();
    endtask

    initial
    begin
        int k;
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        issue(ACT_NONE, 8'hFF, 8'hFF);
        issue(ACT_ALLOC_L, 8'd0, 8'd0);
        // busy mask survives, so v0 lands on the next register
        send_beat(ACT_NEW_FN, 8'd0, 8'd0);
        issue(ACT_ALLOC_L, 8'd0, 8'd0);
        issue(ACT_ALLOC_L, 8'd0, 8'hFF);
        issue(ACT_ALLOC_LR, 8'hFF, 8'hFF);
        issue(ACT_ALLOC_LR, 8'd1, 8'd2);
        issue(ACT_KILL, 8'd0, 8'd0);
        // stale mapping, then kill of a free register, then of an unmapped one
        issue(ACT_ALLOC_L, 8'd0, 8'd0);
        issue(ACT_KILL, 8'd0, 8'd0);
        issue(ACT_KILL, 8'd7, 8'd0);
        issue(ACT_UNUSED_A, 8'hAA, 8'h55);
        issue(ACT_UNUSED_B, 8'h55, 8'hAA);
        issue(ACT_ALLOC_LR, 8'd3, 8'd4);
        issue(ACT_ALLOC_L, 8'd5, 8'd0);
        // rhs runs out, lhs allocation rolls back
        issue(ACT_ALLOC_LR, 8'd8, 8'd9);
        issue(ACT_ALLOC_L, 8'd8, 8'd0);
        issue(ACT_ALLOC_L, 8'd9, 8'd0);
        for (k = 0; k < 9; k++)
            issue(ACT_ALLOC_ARG, 8'(200 + k), 8'd0);
        issue(ACT_ALLOC_ARG, 8'd200, 8'd0);

        run_phase(0, 0, 170, 1'b1);
        run_phase(83, 0, 150, 1'b0);
        run_phase(0, 83, 150, 1'b0);
        run_phase(33, 33, 150, 1'b0);
        run_phase(0, 0, 160, 1'b0);
        drain();
        repeat (20) @(negedge clk);

        if (errors == 0 && pending == 0)
            $display("[virtual_register_allocator] OK");
        else
            $display("[virtual_register_allocator] ERROR");
        $finish;
    end

endmodule
